### src/lmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared codes, register map and item types for the line message deframer.
// ----------------------------------------------------------------------------
package lmd_pkg;

   // request codes
   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_DATA  = 2'd1;
   localparam logic [1:0] REQ_CLOSE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_START_MARKER = 2'd0;
   localparam logic [1:0] REG_LINE_LIMIT   = 2'd1;
   localparam logic [1:0] REG_BYTE_LIMIT   = 2'd2;
   localparam logic [1:0] REG_CHAR_LIMIT   = 2'd3;

   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   localparam logic [7:0] START_MARKER_RST = 8'd1;
   localparam logic [7:0] LINE_LIMIT_RST   = 8'd16;
   localparam logic [7:0] BYTE_LIMIT_RST   = 8'd255;
   localparam logic [7:0] CHAR_LIMIT_RST   = 8'd255;

   // allowed range of the next UTF-8 continuation byte
   typedef enum logic [2:0] {
      RNG_ANY  = 3'd0,
      RNG_A0BF = 3'd1,
      RNG_809F = 3'd2,
      RNG_90BF = 3'd3,
      RNG_808F = 3'd4
   } rng_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] line_limit;
      logic [7:0] byte_limit;
      logic [7:0] char_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] line_index;
      logic       line_last;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] cont_left;
      rng_type    cont_range;
      logic [7:0] chars_seen;
   } utf8_res_type;

endpackage

### src/lmd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_req_if
// Input channel: connection events and received bytes.
// ----------------------------------------------------------------------------
interface lmd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

### src/lmd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_rsp_if
// Result channel: status and payload byte with its line index.
// ----------------------------------------------------------------------------
interface lmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic [7:0] line_index;
   logic       line_last;

   modport source (output valid, output status, output payload_valid, output payload_byte,
                   output line_index, output line_last, input ready);
   modport sink   (input valid, input status, input payload_valid, input payload_byte,
                   input line_index, input line_last, output ready);
endinterface

### src/lmd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_csr
// APB-style register bank holding the start marker and the three limit registers.
// ----------------------------------------------------------------------------
module lmd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lmd_pkg::ADDR_W-1:0]    paddr,
   input  logic [lmd_pkg::DATA_W-1:0]    pwdata,
   output logic [lmd_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output lmd_pkg::cfg_type              cfg
);

   lmd_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       reg_idx;
   logic             wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            lmd_pkg::REG_START_MARKER: cfg_in.start_marker = pwdata[7:0];
            lmd_pkg::REG_LINE_LIMIT:   cfg_in.line_limit   = pwdata[7:0];
            lmd_pkg::REG_BYTE_LIMIT:   cfg_in.byte_limit   = pwdata[7:0];
            lmd_pkg::REG_CHAR_LIMIT:   cfg_in.char_limit   = pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         lmd_pkg::REG_START_MARKER: prdata[7:0] = cfg_ff.start_marker;
         lmd_pkg::REG_LINE_LIMIT:   prdata[7:0] = cfg_ff.line_limit;
         lmd_pkg::REG_BYTE_LIMIT:   prdata[7:0] = cfg_ff.byte_limit;
         lmd_pkg::REG_CHAR_LIMIT:   prdata[7:0] = cfg_ff.char_limit;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= lmd_pkg::START_MARKER_RST;
         cfg_ff.line_limit   <= lmd_pkg::LINE_LIMIT_RST;
         cfg_ff.byte_limit   <= lmd_pkg::BYTE_LIMIT_RST;
         cfg_ff.char_limit   <= lmd_pkg::CHAR_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/lmd_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_utf8
// Strict UTF-8 check of one line byte, with character count against limit.
// ----------------------------------------------------------------------------
module lmd_utf8 (
   input  logic [7:0]            data_byte,
   input  logic [1:0]            cont_left,
   input  lmd_pkg::rng_type      cont_range,
   input  logic [7:0]            chars_seen,
   input  logic [7:0]            char_limit,
   output lmd_pkg::utf8_res_type res
);

   logic cont_ok;
   logic lead_ok;

   always_comb begin
      case (cont_range)
         lmd_pkg::RNG_A0BF: cont_ok = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
         lmd_pkg::RNG_809F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
         lmd_pkg::RNG_90BF: cont_ok = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
         lmd_pkg::RNG_808F: cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
         default:           cont_ok = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
      endcase
   end

   always_comb begin
      res.ok         = 1'b0;
      res.cont_left  = 2'd0;
      res.cont_range = lmd_pkg::RNG_ANY;
      res.chars_seen = chars_seen;
      lead_ok        = 1'b1;
      if (cont_left != 2'd0) begin
         res.ok        = cont_ok;
         res.cont_left = cont_left - 2'd1;
      end else begin
         case (data_byte) inside
            8'h00:           lead_ok = 1'b0;   // NUL not allowed in a line
            [8'h01:8'h7F]:   res.cont_left = 2'd0;
            [8'hC2:8'hDF]:   res.cont_left = 2'd1;
            8'hE0: begin
               res.cont_left  = 2'd2;
               res.cont_range = lmd_pkg::RNG_A0BF;
            end
            8'hED: begin
               res.cont_left  = 2'd2;
               res.cont_range = lmd_pkg::RNG_809F;
            end
            [8'hE1:8'hEF]:   res.cont_left = 2'd2;
            8'hF0: begin
               res.cont_left  = 2'd3;
               res.cont_range = lmd_pkg::RNG_90BF;
            end
            [8'hF1:8'hF3]:   res.cont_left = 2'd3;
            8'hF4: begin
               res.cont_left  = 2'd3;
               res.cont_range = lmd_pkg::RNG_808F;
            end
            default:         lead_ok = 1'b0;
         endcase
         res.ok         = lead_ok && (chars_seen < char_limit);
         res.chars_seen = chars_seen + 8'd1;
      end
   end

endmodule

### src/lmd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_core
// Input register, message state machine and result register.
// ----------------------------------------------------------------------------
module lmd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  lmd_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lmd_pkg::item_type     req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lmd_pkg::result_type   rsp_item
);

   typedef enum logic [8:0] {
      PH_IDLE  = 9'b000000001,
      PH_START = 9'b000000010,
      PH_COUNT = 9'b000000100,
      PH_LEN   = 9'b000001000,
      PH_BODY  = 9'b000010000,
      PH_TAIL0 = 9'b000100000,
      PH_TAIL1 = 9'b001000000,
      PH_CLOSE = 9'b010000000,
      PH_ERR   = 9'b100000000
   } phase_type;

   logic                 in_vld_ff, in_vld_in;
   lmd_pkg::item_type    in_item_ff;
   logic                 out_vld_ff, out_vld_in;
   lmd_pkg::result_type  out_item_ff, out_item_in;

   phase_type            phase_ff, phase_in;
   logic [7:0]           lines_ff, lines_in;
   logic [7:0]           cur_line_ff, cur_line_in;
   logic [7:0]           bytes_left_ff, bytes_left_in;
   logic [7:0]           chars_ff, chars_in;
   logic [1:0]           cont_left_ff, cont_left_in;
   lmd_pkg::rng_type     cont_range_ff, cont_range_in;

   logic                 advance;
   logic                 take;
   logic [7:0]           next_line;
   logic [7:0]           bytes_dec;
   lmd_pkg::utf8_res_type u8;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign take      = req_valid && req_ready;
   assign next_line = cur_line_ff + 8'd1;
   assign bytes_dec = bytes_left_ff - 8'd1;

   lmd_utf8 u_utf8 (
      .data_byte  (in_item_ff.data_byte),
      .cont_left  (cont_left_ff),
      .cont_range (cont_range_ff),
      .chars_seen (chars_ff),
      .char_limit (cfg.char_limit),
      .res        (u8)
   );

   always_comb begin
      logic       ok;
      logic [7:0] b;
      ok            = 1'b1;
      b             = in_item_ff.data_byte;
      phase_in      = phase_ff;
      lines_in      = lines_ff;
      cur_line_in   = cur_line_ff;
      bytes_left_in = bytes_left_ff;
      chars_in      = chars_ff;
      cont_left_in  = cont_left_ff;
      cont_range_in = cont_range_ff;
      out_item_in   = '0;

      case (in_item_ff.req_type)
         lmd_pkg::REQ_OPEN: begin
            phase_in           = PH_START;
            lines_in           = 8'd0;
            cur_line_in        = 8'd0;
            bytes_left_in      = 8'd0;
            chars_in           = 8'd0;
            cont_left_in       = 2'd0;
            cont_range_in      = lmd_pkg::RNG_ANY;
            out_item_in.status = lmd_pkg::ST_BUSY;
         end
         lmd_pkg::REQ_CLOSE: begin
            if (phase_ff == PH_IDLE)       out_item_in.status = lmd_pkg::ST_IDLE;
            else if (phase_ff == PH_CLOSE) out_item_in.status = lmd_pkg::ST_DONE;
            else                           out_item_in.status = lmd_pkg::ST_ERROR;
            phase_in = PH_IDLE;
         end
         lmd_pkg::REQ_DATA: begin
            if (phase_ff == PH_IDLE) begin
               out_item_in.status = lmd_pkg::ST_IDLE;
            end else if (phase_ff == PH_ERR) begin
               out_item_in.status = lmd_pkg::ST_ERROR;
            end else begin
               unique case (phase_ff)
                  PH_START: begin
                     if (b != cfg.start_marker) ok = 1'b0;
                     else phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     if (b > cfg.line_limit) begin
                        ok = 1'b0;
                     end else begin
                        lines_in    = b;
                        cur_line_in = 8'd0;
                        phase_in    = (b == 8'd0) ? PH_TAIL0 : PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     if (b > cfg.byte_limit) begin
                        ok = 1'b0;
                     end else begin
                        bytes_left_in = b;
                        chars_in      = 8'd0;
                        cont_left_in  = 2'd0;
                        cont_range_in = lmd_pkg::RNG_ANY;
                        if (b == 8'd0) begin
                           // empty line: straight on to the next one
                           cur_line_in = next_line;
                           phase_in    = (next_line == lines_ff) ? PH_TAIL0 : PH_LEN;
                        end else begin
                           phase_in = PH_BODY;
                        end
                     end
                  end
                  PH_BODY: begin
                     if (!u8.ok) begin
                        ok = 1'b0;
                     end else if (bytes_dec == 8'd0 && u8.cont_left != 2'd0) begin
                        ok = 1'b0;   // line ends inside a character
                     end else begin
                        bytes_left_in            = bytes_dec;
                        chars_in                 = u8.chars_seen;
                        cont_left_in             = u8.cont_left;
                        cont_range_in            = u8.cont_range;
                        out_item_in.payload_valid = 1'b1;
                        out_item_in.payload_byte  = b;
                        out_item_in.line_index    = cur_line_ff;
                        if (bytes_dec == 8'd0) begin
                           out_item_in.line_last = 1'b1;
                           cur_line_in           = next_line;
                           phase_in = (next_line == lines_ff) ? PH_TAIL0 : PH_LEN;
                        end
                     end
                  end
                  PH_TAIL0: begin
                     if (b != 8'd0) ok = 1'b0;
                     else phase_in = PH_TAIL1;
                  end
                  PH_TAIL1: begin
                     if (b != 8'd0) ok = 1'b0;
                     else phase_in = PH_CLOSE;
                  end
                  default: ok = 1'b0;   // data where close was due
               endcase
               if (ok) begin
                  out_item_in.status = lmd_pkg::ST_BUSY;
               end else begin
                  phase_in           = PH_ERR;
                  out_item_in        = '0;
                  out_item_in.status = lmd_pkg::ST_ERROR;
               end
            end
         end
         default: begin
            if (phase_ff == PH_IDLE)     out_item_in.status = lmd_pkg::ST_IDLE;
            else if (phase_ff == PH_ERR) out_item_in.status = lmd_pkg::ST_ERROR;
            else                         out_item_in.status = lmd_pkg::ST_BUSY;
         end
      endcase
   end

   always_comb begin
      if (take)         in_vld_in = 1'b1;
      else if (advance) in_vld_in = 1'b0;
      else              in_vld_in = in_vld_ff;
      if (advance)        out_vld_in = 1'b1;
      else if (rsp_ready) out_vld_in = 1'b0;
      else                out_vld_in = out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         phase_ff      <= PH_IDLE;
         lines_ff      <= 8'd0;
         cur_line_ff   <= 8'd0;
         bytes_left_ff <= 8'd0;
         chars_ff      <= 8'd0;
         cont_left_ff  <= 2'd0;
         cont_range_ff <= lmd_pkg::RNG_ANY;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            phase_ff      <= phase_in;
            lines_ff      <= lines_in;
            cur_line_ff   <= cur_line_in;
            bytes_left_ff <= bytes_left_in;
            chars_ff      <= chars_in;
            cont_left_ff  <= cont_left_in;
            cont_range_ff <= cont_range_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take)    in_item_ff  <= req_item;
      if (advance) out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

endmodule

### src/line_message_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_message_deframer_top
// Deframes one connection's byte stream into checked UTF-8 lines.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries connection events (open, data byte, close); every item
//   gives exactly one item on rsp_chan with a status and, for line bytes,
//   the byte, its line index and an end-of-line flag.
//   Status 2 on the close item is the only confirmation of a message; bytes
//   passed out before an error must be dropped downstream.
//   An accepted item is held in the input register, processed from there, and
//   its result is written to the result register that drives rsp_chan.
//   Throughput: one item per cycle while rsp_chan.ready stays high; the message
//   state updates in a single registered step per byte.
//   Stalls: the result register holds while rsp_chan.ready is low, and the
//   input register still takes one more item before req_chan.ready drops.
//   Reset: both channels empty, the parser idle, registers at their defaults
//   (start marker 1, line limit 16, byte and char limits 255).
//   Registers sit at byte addresses 0, 4, 8 and 12; the user must write them only
//   while no item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module line_message_deframer_top (
   input  logic                        clock,
   input  logic                        reset,
   lmd_req_if.sink                     req_chan,
   lmd_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lmd_pkg::ADDR_W-1:0]  paddr,
   input  logic [lmd_pkg::DATA_W-1:0]  pwdata,
   output logic [lmd_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   lmd_pkg::cfg_type    cfg;
   lmd_pkg::item_type   req_item;
   lmd_pkg::result_type rsp_item;

   assign req_item.req_type  = req_chan.req_type;
   assign req_item.data_byte = req_chan.data_byte;

   lmd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lmd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_item  (req_item),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.status        = rsp_item.status;
   assign rsp_chan.payload_valid = rsp_item.payload_valid;
   assign rsp_chan.payload_byte  = rsp_item.payload_byte;
   assign rsp_chan.line_index    = rsp_item.line_index;
   assign rsp_chan.line_last     = rsp_item.line_last;

endmodule

### src/lmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module lmd_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_line_index,
   input logic       rsp_line_last
);

   // nothing comes out straight after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_payload_byte)
         && $stable(rsp_line_index) && $stable(rsp_payload_valid))
      else $error("stalled result changed");

   // a line byte is only passed out while a message is in progress
   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_status == lmd_pkg::ST_BUSY)
      else $error("payload byte with status other than in progress");

   a_no_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |->
         rsp_payload_byte == 8'd0 && rsp_line_index == 8'd0 && !rsp_line_last)
      else $error("payload fields not cleared without a line byte");

   // a payload byte in a line is never NUL
   a_no_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_payload_byte != 8'd0)
      else $error("NUL byte passed out");

endmodule

bind line_message_deframer_top lmd_port_checks u_lmd_port_checks (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_payload_valid (rsp_chan.payload_valid),
   .rsp_payload_byte  (rsp_chan.payload_byte),
   .rsp_line_index    (rsp_chan.line_index),
   .rsp_line_last     (rsp_chan.line_last)
);
